// ===== hw/rtl/dtc_pkg.sv =====
// shared types and constants of the dual timer/counter
package dtc_pkg;

    localparam int CMD_W  = 2;
    localparam int SEL_W  = 3;
    localparam int BYTE_W = 8;
    localparam int MODE_W = 2;

    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    localparam logic [SEL_W-1:0] SEL_CONTROL = 3'd0;
    localparam logic [SEL_W-1:0] SEL_LOW0    = 3'd1;
    localparam logic [SEL_W-1:0] SEL_LOW1    = 3'd2;
    localparam logic [SEL_W-1:0] SEL_HIGH0   = 3'd3;
    localparam logic [SEL_W-1:0] SEL_HIGH1   = 3'd4;

    localparam logic [MODE_W-1:0] MODE_13BIT  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_16BIT  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RELOAD = 2'd2;
    localparam logic [MODE_W-1:0] MODE_SPLIT  = 2'd3;

    // control byte bit positions
    localparam int CTRL_RUN0  = 4;
    localparam int CTRL_FLAG0 = 5;
    localparam int CTRL_RUN1  = 6;
    localparam int CTRL_FLAG1 = 7;

    // mode byte bit positions
    localparam int TMOD_MODE0_LSB = 0;
    localparam int TMOD_CT0       = 2;
    localparam int TMOD_GATE0     = 3;
    localparam int TMOD_MODE1_LSB = 4;
    localparam int TMOD_CT1       = 6;
    localparam int TMOD_GATE1     = 7;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [SEL_W-1:0]  reg_select;
        logic [BYTE_W-1:0] write_data;
    } t_item;

    typedef struct packed {
        logic [BYTE_W-1:0] read_data;
        logic              overflow_zero;
        logic              overflow_one;
    } t_result;

endpackage

// ===== hw/rtl/dtc_ifs.sv =====
// handshake channels of the dual timer/counter
interface dtc_item_if;
    logic                          valid;
    logic                          ready;
    logic [dtc_pkg::CMD_W-1:0]     command;
    logic [dtc_pkg::SEL_W-1:0]     reg_select;
    logic [dtc_pkg::BYTE_W-1:0]    write_data;

    modport source (output valid, command, reg_select, write_data, input ready);
    modport sink   (input valid, command, reg_select, write_data, output ready);
endinterface

interface dtc_result_if;
    logic                          valid;
    logic                          ready;
    logic [dtc_pkg::BYTE_W-1:0]    read_data;
    logic                          overflow_zero;
    logic                          overflow_one;

    modport source (output valid, read_data, overflow_zero, overflow_one, input ready);
    modport sink   (input valid, read_data, overflow_zero, overflow_one, output ready);
endinterface

interface dtc_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [dtc_pkg::BYTE_W-1:0]    timer_mode;

    modport source (output valid, timer_mode, input ready);
    modport sink   (input valid, timer_mode, output ready);
endinterface

// ===== hw/rtl/dtc_pair.sv =====
// one timer pair advanced by a single tick in 13-bit, 16-bit or reload mode
module dtc_pair (
    input  logic [dtc_pkg::MODE_W-1:0] i_mode,
    input  logic                       i_en,
    input  logic [dtc_pkg::BYTE_W-1:0] i_low,
    input  logic [dtc_pkg::BYTE_W-1:0] i_high,
    output logic [dtc_pkg::BYTE_W-1:0] o_low,
    output logic [dtc_pkg::BYTE_W-1:0] o_high,
    output logic                       o_ovf
);

    logic [5:0]                   low5_inc;
    logic [dtc_pkg::BYTE_W-1:0]   low_inc;
    logic [dtc_pkg::BYTE_W-1:0]   high_inc;
    logic                         low_full;
    logic                         high_full;

    assign low5_inc  = {1'b0, i_low[4:0]} + 6'd1;
    assign low_inc   = i_low + 8'd1;
    assign high_inc  = i_high + 8'd1;
    assign low_full  = (i_low == 8'hFF);
    assign high_full = (i_high == 8'hFF);

    always_comb begin
        o_low  = i_low;
        o_high = i_high;
        o_ovf  = 1'b0;
        if (i_en) begin
            case (i_mode)
                dtc_pkg::MODE_13BIT: begin
                    o_low = {i_low[7:5], low5_inc[4:0]};
                    if (low5_inc[5]) begin
                        o_high = high_inc;
                        o_ovf  = high_full;
                    end
                end
                dtc_pkg::MODE_16BIT: begin
                    o_low = low_inc;
                    if (low_full) begin
                        o_high = high_inc;
                        o_ovf  = high_full;
                    end
                end
                dtc_pkg::MODE_RELOAD: begin
                    if (low_full) begin
                        o_low = i_high;
                        o_ovf = 1'b1;
                    end else begin
                        o_low = low_inc;
                    end
                end
                default: begin
                    o_low  = i_low;
                    o_high = i_high;
                    o_ovf  = 1'b0;
                end
            endcase
        end
    end

endmodule

// ===== hw/rtl/dtc_regs.sv =====
// timer state registers with tick, register write and register read decode
module dtc_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_fire,
    input  dtc_pkg::t_item             i_item,
    input  logic [dtc_pkg::BYTE_W-1:0] i_timer_mode,
    output dtc_pkg::t_result           o_result
);

    logic [dtc_pkg::BYTE_W-1:0] r_ctrl, r_lo0, r_hi0, r_lo1, r_hi1;
    logic [dtc_pkg::BYTE_W-1:0] n_ctrl, n_lo0, n_hi0, n_lo1, n_hi1;

    logic [dtc_pkg::MODE_W-1:0] mode0, mode1;
    logic                       en0, en1, split0;
    logic [dtc_pkg::BYTE_W-1:0] p0_lo, p0_hi, p1_lo, p1_hi;
    logic                       p0_ovf, p1_ovf;
    logic                       ov0, ov1;

    assign mode0  = i_timer_mode[dtc_pkg::TMOD_MODE0_LSB +: dtc_pkg::MODE_W];
    assign mode1  = i_timer_mode[dtc_pkg::TMOD_MODE1_LSB +: dtc_pkg::MODE_W];
    assign split0 = (mode0 == dtc_pkg::MODE_SPLIT);
    assign en0    = r_ctrl[dtc_pkg::CTRL_RUN0] & ~i_timer_mode[dtc_pkg::TMOD_GATE0]
                    & ~i_timer_mode[dtc_pkg::TMOD_CT0];
    assign en1    = r_ctrl[dtc_pkg::CTRL_RUN1] & ~i_timer_mode[dtc_pkg::TMOD_GATE1]
                    & ~i_timer_mode[dtc_pkg::TMOD_CT1];

    dtc_pair u_pair0 (
        .i_mode (mode0),
        .i_en   (en0),
        .i_low  (r_lo0),
        .i_high (r_hi0),
        .o_low  (p0_lo),
        .o_high (p0_hi),
        .o_ovf  (p0_ovf)
    );

    dtc_pair u_pair1 (
        .i_mode (mode1),
        .i_en   (en1),
        .i_low  (r_lo1),
        .i_high (r_hi1),
        .o_low  (p1_lo),
        .o_high (p1_hi),
        .o_ovf  (p1_ovf)
    );

    always_comb begin
        n_ctrl   = r_ctrl;
        n_lo0    = r_lo0;
        n_hi0    = r_hi0;
        n_lo1    = r_lo1;
        n_hi1    = r_hi1;
        ov0      = 1'b0;
        ov1      = 1'b0;
        o_result = '0;
        case (i_item.command)
            dtc_pkg::CMD_TICK: begin
                if (split0) begin
                    // timer 0 split into two 8-bit counters
                    if (en0) begin
                        n_lo0 = r_lo0 + 8'd1;
                        ov0   = (r_lo0 == 8'hFF);
                    end
                    if (r_ctrl[dtc_pkg::CTRL_RUN1]) begin
                        n_hi0 = r_hi0 + 8'd1;
                        ov1   = (r_hi0 == 8'hFF);
                    end
                end else begin
                    n_lo0 = p0_lo;
                    n_hi0 = p0_hi;
                    ov0   = p0_ovf;
                end
                n_lo1 = p1_lo;
                n_hi1 = p1_hi;
                ov1   = ov1 | p1_ovf;
                if (ov0) begin
                    n_ctrl[dtc_pkg::CTRL_FLAG0] = 1'b1;
                end
                if (ov1) begin
                    n_ctrl[dtc_pkg::CTRL_FLAG1] = 1'b1;
                end
                o_result.overflow_zero = ov0;
                o_result.overflow_one  = ov1;
            end
            dtc_pkg::CMD_WRITE: begin
                case (i_item.reg_select)
                    dtc_pkg::SEL_CONTROL: n_ctrl = i_item.write_data;
                    dtc_pkg::SEL_LOW0:    n_lo0  = i_item.write_data;
                    dtc_pkg::SEL_LOW1:    n_lo1  = i_item.write_data;
                    dtc_pkg::SEL_HIGH0:   n_hi0  = i_item.write_data;
                    dtc_pkg::SEL_HIGH1:   n_hi1  = i_item.write_data;
                    default:              n_ctrl = r_ctrl;
                endcase
            end
            dtc_pkg::CMD_READ: begin
                case (i_item.reg_select)
                    dtc_pkg::SEL_CONTROL: o_result.read_data = r_ctrl;
                    dtc_pkg::SEL_LOW0:    o_result.read_data = r_lo0;
                    dtc_pkg::SEL_LOW1:    o_result.read_data = r_lo1;
                    dtc_pkg::SEL_HIGH0:   o_result.read_data = r_hi0;
                    dtc_pkg::SEL_HIGH1:   o_result.read_data = r_hi1;
                    default:              o_result.read_data = '0;
                endcase
            end
            default: begin
                o_result = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl <= '0;
            r_lo0  <= '0;
            r_hi0  <= '0;
            r_lo1  <= '0;
            r_hi1  <= '0;
        end else if (i_fire) begin
            r_ctrl <= n_ctrl;
            r_lo0  <= n_lo0;
            r_hi0  <= n_hi0;
            r_lo1  <= n_lo1;
            r_hi1  <= n_hi1;
        end
    end

endmodule

// ===== hw/rtl/dual_timer_counter_four_mode_unit.sv =====
// Two 8051-style timer/counters (timer 0 and timer 1) in modes 0 to 3, driven by tick, register
// write and register read beats. One beat is taken every clock cycle unless the result channel
// stalls: a beat sits in the input register while the timer state and the result are worked
// out in a single pass, then the state registers update and the result moves to the output
// register, from which it is offered. Back pressure on the result channel stalls the input
// register and from there the input channel; the mode byte is written through the configuration
// channel, always ready; the user must write it only while no beat is in flight (not enforced).
module dual_timer_counter_four_mode_unit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    dtc_item_if.sink       i_item,
    dtc_result_if.source   o_result,
    dtc_cfg_if.sink        i_cfg
);

    logic                       r_in_valid;
    dtc_pkg::t_item             r_item;
    logic                       r_out_valid;
    dtc_pkg::t_result           r_result;
    logic [dtc_pkg::BYTE_W-1:0] r_timer_mode;

    dtc_pkg::t_result           core_result;
    logic                       move;
    logic                       in_fire;

    assign move    = r_in_valid & (~r_out_valid | o_result.ready);
    assign in_fire = i_item.valid & i_item.ready;

    assign i_item.ready           = ~r_in_valid | move;
    assign i_cfg.ready            = 1'b1;
    assign o_result.valid         = r_out_valid;
    assign o_result.read_data     = r_result.read_data;
    assign o_result.overflow_zero = r_result.overflow_zero;
    assign o_result.overflow_one  = r_result.overflow_one;

    dtc_regs u_regs (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (move),
        .i_item       (r_item),
        .i_timer_mode (r_timer_mode),
        .o_result     (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_timer_mode <= '0;
        end else begin
            if (in_fire) begin
                r_in_valid <= 1'b1;
            end else if (move) begin
                r_in_valid <= 1'b0;
            end
            if (move) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg.valid) begin
                r_timer_mode <= i_cfg.timer_mode;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_item.command    <= i_item.command;
            r_item.reg_select <= i_item.reg_select;
            r_item.write_data <= i_item.write_data;
        end
        if (move) begin
            r_result <= core_result;
        end
    end

    // only a read beat returns register data
    a_read_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        move && r_item.command != dtc_pkg::CMD_READ |=> r_result.read_data == '0)
        else $error("read data on a beat that is not a read");

    // only a tick beat reports an overflow
    a_ovf_tick_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        move && r_item.command != dtc_pkg::CMD_TICK
        |=> !r_result.overflow_zero && !r_result.overflow_one)
        else $error("overflow reported on a beat that is not a tick");

    // a held item leaves the input register only into a free output register
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_result.ready && r_in_valid |=> r_out_valid && r_in_valid)
        else $error("stalled beat lost");

endmodule

// ===== bench/testbench.sv =====
// self-checking bench for the dual timer/counter: streams beats and predicts each result
`timescale 1ns / 1ps

module testbench;

    localparam logic [dtc_pkg::CMD_W-1:0] CMD_UNUSED     = 2'd3;
    localparam logic [dtc_pkg::SEL_W-1:0] SEL_NONE_FIRST = 3'd5;
    localparam logic [dtc_pkg::SEL_W-1:0] SEL_NONE_LAST  = 3'd7;
    localparam int BEATS_PER_PHASE = 82;
    localparam int SETTLE_CYCLES   = 4;

    logic clk;
    logic rst_n;

    dtc_item_if   item_ch ();
    dtc_result_if result_ch ();
    dtc_cfg_if    cfg_ch ();

    dual_timer_counter_four_mode_unit u_top (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_item   (item_ch),
        .o_result (result_ch),
        .i_cfg    (cfg_ch)
    );

    dtc_pkg::t_item   pending_beats[$];
    dtc_pkg::t_result expected_results[$];

    // predicted timer state
    logic [7:0] mode_shadow;
    logic [7:0] ctrl_shadow;
    logic [7:0] low0_shadow;
    logic [7:0] high0_shadow;
    logic [7:0] low1_shadow;
    logic [7:0] high1_shadow;

    bit item_fire;
    bit calm;
    bit long_hold_done;
    int hold_left;
    int results_seen;
    int error_count;

    always #1 clk = ~clk;

    // returns {overflow, high, low} after one count of a pair in modes 0 to 2
    function automatic logic [16:0] count_pair(input logic [15:0] pair,
                                               input logic [dtc_pkg::MODE_W-1:0] mode);
        logic [7:0] lo;
        logic [7:0] hi;
        logic [5:0] low5;
        logic       ovf;
        lo   = pair[7:0];
        hi   = pair[15:8];
        ovf  = 1'b0;
        case (mode)
            dtc_pkg::MODE_13BIT: begin
                low5 = {1'b0, lo[4:0]} + 6'd1;
                if (low5[5]) begin
                    lo  = {lo[7:5], 5'd0};
                    hi  = hi + 8'd1;
                    ovf = (hi == 8'd0);
                end else begin
                    lo = {lo[7:5], low5[4:0]};
                end
            end
            dtc_pkg::MODE_16BIT: begin
                lo = lo + 8'd1;
                if (lo == 8'd0) begin
                    hi  = hi + 8'd1;
                    ovf = (hi == 8'd0);
                end
            end
            dtc_pkg::MODE_RELOAD: begin
                if (lo == 8'hFF) begin
                    lo  = hi;
                    ovf = 1'b1;
                end else begin
                    lo = lo + 8'd1;
                end
            end
            default: ovf = 1'b0;
        endcase
        return {ovf, hi, lo};
    endfunction

    function dtc_pkg::t_result timer_step(input dtc_pkg::t_item beat);
        dtc_pkg::t_result           res;
        logic [dtc_pkg::MODE_W-1:0] m0;
        logic [dtc_pkg::MODE_W-1:0] m1;
        logic                       en0;
        logic                       en1;
        logic [16:0]                nxt;
        res = '0;
        m0  = mode_shadow[dtc_pkg::TMOD_MODE0_LSB +: dtc_pkg::MODE_W];
        m1  = mode_shadow[dtc_pkg::TMOD_MODE1_LSB +: dtc_pkg::MODE_W];
        en0 = ctrl_shadow[dtc_pkg::CTRL_RUN0] && !mode_shadow[dtc_pkg::TMOD_GATE0]
              && !mode_shadow[dtc_pkg::TMOD_CT0];
        en1 = ctrl_shadow[dtc_pkg::CTRL_RUN1] && !mode_shadow[dtc_pkg::TMOD_GATE1]
              && !mode_shadow[dtc_pkg::TMOD_CT1];
        case (beat.command)
            dtc_pkg::CMD_TICK: begin
                if (m0 == dtc_pkg::MODE_SPLIT) begin
                    if (en0) begin
                        low0_shadow = low0_shadow + 8'd1;
                        if (low0_shadow == 8'd0) res.overflow_zero = 1'b1;
                    end
                    if (ctrl_shadow[dtc_pkg::CTRL_RUN1]) begin
                        high0_shadow = high0_shadow + 8'd1;
                        if (high0_shadow == 8'd0) res.overflow_one = 1'b1;
                    end
                end else if (en0) begin
                    nxt = count_pair({high0_shadow, low0_shadow}, m0);
                    {high0_shadow, low0_shadow} = nxt[15:0];
                    if (nxt[16]) res.overflow_zero = 1'b1;
                end
                if (en1 && m1 != dtc_pkg::MODE_SPLIT) begin
                    nxt = count_pair({high1_shadow, low1_shadow}, m1);
                    {high1_shadow, low1_shadow} = nxt[15:0];
                    if (nxt[16]) res.overflow_one = 1'b1;
                end
                if (res.overflow_zero) ctrl_shadow[dtc_pkg::CTRL_FLAG0] = 1'b1;
                if (res.overflow_one) ctrl_shadow[dtc_pkg::CTRL_FLAG1] = 1'b1;
            end
            dtc_pkg::CMD_WRITE: begin
                case (beat.reg_select)
                    dtc_pkg::SEL_CONTROL: ctrl_shadow  = beat.write_data;
                    dtc_pkg::SEL_LOW0:    low0_shadow  = beat.write_data;
                    dtc_pkg::SEL_LOW1:    low1_shadow  = beat.write_data;
                    dtc_pkg::SEL_HIGH0:   high0_shadow = beat.write_data;
                    dtc_pkg::SEL_HIGH1:   high1_shadow = beat.write_data;
                    default: ;
                endcase
            end
            dtc_pkg::CMD_READ: begin
                case (beat.reg_select)
                    dtc_pkg::SEL_CONTROL: res.read_data = ctrl_shadow;
                    dtc_pkg::SEL_LOW0:    res.read_data = low0_shadow;
                    dtc_pkg::SEL_LOW1:    res.read_data = low1_shadow;
                    dtc_pkg::SEL_HIGH0:   res.read_data = high0_shadow;
                    dtc_pkg::SEL_HIGH1:   res.read_data = high1_shadow;
                    default:              res.read_data = 8'd0;
                endcase
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic dtc_pkg::t_item make_beat(input logic [dtc_pkg::CMD_W-1:0] cmd,
                                                 input logic [dtc_pkg::SEL_W-1:0] sel,
                                                 input logic [dtc_pkg::BYTE_W-1:0] data);
        dtc_pkg::t_item beat;
        beat.command    = cmd;
        beat.reg_select = sel;
        beat.write_data = data;
        return beat;
    endfunction

    function automatic logic [dtc_pkg::SEL_W-1:0] pick_select();
        if ($urandom_range(99) < 90)
            return dtc_pkg::SEL_W'($urandom_range(dtc_pkg::SEL_CONTROL, dtc_pkg::SEL_HIGH1));
        return dtc_pkg::SEL_W'($urandom_range(SEL_NONE_FIRST, SEL_NONE_LAST));
    endfunction

    // mostly ticks, with writes that park the counters close to overflow
    function automatic dtc_pkg::t_item random_beat();
        dtc_pkg::t_item beat;
        int             pick;
        pick            = $urandom_range(99);
        beat.command    = dtc_pkg::CMD_TICK;
        beat.reg_select = dtc_pkg::SEL_W'($urandom);
        beat.write_data = dtc_pkg::BYTE_W'($urandom);
        if (pick >= 58 && pick < 80) begin
            beat.command    = dtc_pkg::CMD_WRITE;
            beat.reg_select = pick_select();
            if (beat.reg_select == dtc_pkg::SEL_CONTROL) begin
                beat.write_data[dtc_pkg::CTRL_RUN0] = ($urandom_range(99) < 85);
                beat.write_data[dtc_pkg::CTRL_RUN1] = ($urandom_range(99) < 85);
            end else if ($urandom_range(99) < 60) begin
                if ($urandom_range(1) == 0)
                    beat.write_data = dtc_pkg::BYTE_W'($urandom_range(8'hF8, 8'hFF));
                else
                    beat.write_data[4:0] = 5'($urandom_range(5'd27, 5'd31));
            end
        end else if (pick >= 80 && pick < 98) begin
            beat.command    = dtc_pkg::CMD_READ;
            beat.reg_select = pick_select();
        end else if (pick >= 98) begin
            beat.command = CMD_UNUSED;
        end
        return beat;
    endfunction

    // item driver
    always @(negedge clk) begin
        dtc_pkg::t_item beat;
        if (!item_ch.valid || item_fire) begin
            if (pending_beats.size() != 0 && (calm || $urandom_range(99) >= 30)) begin
                beat = pending_beats.pop_front();
                item_ch.valid      <= 1'b1;
                item_ch.command    <= beat.command;
                item_ch.reg_select <= beat.reg_select;
                item_ch.write_data <= beat.write_data;
            end else begin
                item_ch.valid <= 1'b0;
            end
        end
    end

    // result receiver with random stalls and one long hold-off
    always @(negedge clk) begin
        if (hold_left != 0) begin
            result_ch.ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!long_hold_done && results_seen >= 150) begin
            result_ch.ready <= 1'b0;
            hold_left <= 60;
            long_hold_done <= 1'b1;
        end else if ($urandom_range(1999) == 0) begin
            result_ch.ready <= 1'b0;
            hold_left <= $urandom_range(20, 50);
        end else begin
            result_ch.ready <= calm || $urandom_range(99) >= 30;
        end
    end

    // monitor and checker
    always @(posedge clk) begin
        dtc_pkg::t_result want;
        if (rst_n) begin
            if (cfg_ch.valid && cfg_ch.ready) mode_shadow = cfg_ch.timer_mode;
            if (result_ch.valid && result_ch.ready) begin
                results_seen <= results_seen + 1;
                if (expected_results.size() == 0) begin
                    $display("%0t: result beat with nothing expected, read_data %h ov0 %b ov1 %b",
                             $time, result_ch.read_data, result_ch.overflow_zero,
                             result_ch.overflow_one);
                    error_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (result_ch.read_data !== want.read_data) begin
                        $display("%0t: read_data expected %h actual %h",
                                 $time, want.read_data, result_ch.read_data);
                        error_count++;
                    end
                    if (result_ch.overflow_zero !== want.overflow_zero) begin
                        $display("%0t: overflow_zero expected %b actual %b",
                                 $time, want.overflow_zero, result_ch.overflow_zero);
                        error_count++;
                    end
                    if (result_ch.overflow_one !== want.overflow_one) begin
                        $display("%0t: overflow_one expected %b actual %b",
                                 $time, want.overflow_one, result_ch.overflow_one);
                        error_count++;
                    end
                end
            end
            if (item_ch.valid && item_ch.ready)
                expected_results.push_back(timer_step(make_beat(item_ch.command,
                                                                item_ch.reg_select,
                                                                item_ch.write_data)));
        end
        item_fire <= rst_n && item_ch.valid && item_ch.ready;
    end

    task automatic wait_until_quiet();
        forever begin
            @(posedge clk);
            if (pending_beats.size() == 0 && !item_ch.valid && expected_results.size() == 0)
                break;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_timer_mode(input logic [dtc_pkg::BYTE_W-1:0] value);
        @(negedge clk);
        cfg_ch.valid      = 1'b1;
        cfg_ch.timer_mode = value;
        do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    initial begin
        logic [dtc_pkg::BYTE_W-1:0] phase_modes[$];
        phase_modes = '{8'h00, 8'h11, 8'h22, 8'h03, 8'h13, 8'h23, 8'h33, 8'h0B,
                        8'h4C, 8'h85, 8'hFF, 8'($urandom), 8'($urandom)};
        clk                = 1'b0;
        rst_n              = 1'b0;
        item_ch.valid      = 1'b0;
        item_ch.command    = dtc_pkg::CMD_TICK;
        item_ch.reg_select = dtc_pkg::SEL_CONTROL;
        item_ch.write_data = '0;
        result_ch.ready    = 1'b0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.timer_mode  = '0;
        mode_shadow        = '0;
        ctrl_shadow        = '0;
        low0_shadow        = '0;
        high0_shadow       = '0;
        low1_shadow        = '0;
        high1_shadow       = '0;
        calm               = 1'b0;
        long_hold_done     = 1'b0;
        hold_left          = 0;
        results_seen       = 0;
        error_count        = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: both timers overflow together in 13-bit mode, then every register and odd codes
        load_timer_mode(8'h00);
        pending_beats.push_back(make_beat(dtc_pkg::CMD_READ, dtc_pkg::SEL_CONTROL, 8'h00));
        pending_beats.push_back(make_beat(dtc_pkg::CMD_WRITE, dtc_pkg::SEL_CONTROL, 8'h50));
        pending_beats.push_back(make_beat(dtc_pkg::CMD_WRITE, dtc_pkg::SEL_LOW0, 8'hFF));
        pending_beats.push_back(make_beat(dtc_pkg::CMD_WRITE, dtc_pkg::SEL_HIGH0, 8'hFF));
        pending_beats.push_back(make_beat(dtc_pkg::CMD_WRITE, dtc_pkg::SEL_LOW1, 8'h1F));
        pending_beats.push_back(make_beat(dtc_pkg::CMD_WRITE, dtc_pkg::SEL_HIGH1, 8'hFF));
        pending_beats.push_back(make_beat(dtc_pkg::CMD_TICK, dtc_pkg::SEL_CONTROL, 8'h00));
        pending_beats.push_back(make_beat(dtc_pkg::CMD_TICK, SEL_NONE_LAST, 8'hFF));
        pending_beats.push_back(make_beat(dtc_pkg::CMD_READ, dtc_pkg::SEL_CONTROL, 8'h00));
        pending_beats.push_back(make_beat(dtc_pkg::CMD_READ, dtc_pkg::SEL_LOW0, 8'h00));
        pending_beats.push_back(make_beat(dtc_pkg::CMD_READ, dtc_pkg::SEL_LOW1, 8'h00));
        pending_beats.push_back(make_beat(dtc_pkg::CMD_READ, dtc_pkg::SEL_HIGH0, 8'h00));
        pending_beats.push_back(make_beat(dtc_pkg::CMD_READ, dtc_pkg::SEL_HIGH1, 8'h00));
        pending_beats.push_back(make_beat(dtc_pkg::CMD_READ, SEL_NONE_FIRST, 8'h00));
        pending_beats.push_back(make_beat(dtc_pkg::CMD_READ, SEL_NONE_LAST, 8'hFF));
        pending_beats.push_back(make_beat(dtc_pkg::CMD_WRITE, SEL_NONE_LAST - 3'd1, 8'hAA));
        pending_beats.push_back(make_beat(CMD_UNUSED, SEL_NONE_LAST, 8'hFF));
        pending_beats.push_back(make_beat(dtc_pkg::CMD_WRITE, dtc_pkg::SEL_CONTROL, 8'h00));
        pending_beats.push_back(make_beat(dtc_pkg::CMD_TICK, dtc_pkg::SEL_CONTROL, 8'h00));
        pending_beats.push_back(make_beat(dtc_pkg::CMD_READ, dtc_pkg::SEL_CONTROL, 8'h00));
        wait_until_quiet();

        foreach (phase_modes[p]) begin
            load_timer_mode(phase_modes[p]);
            calm = (p == 3 || p == 4);
            pending_beats.push_back(make_beat(dtc_pkg::CMD_WRITE, dtc_pkg::SEL_CONTROL, 8'h50));
            for (int n = 0; n < BEATS_PER_PHASE; n++)
                pending_beats.push_back(random_beat());
            wait_until_quiet();
        end

        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #500000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
